>>> src/ccc_pkg.sv
// ----------------------------------------------------------------------------
// ccc_pkg
// Shared types and codes of the coin change combination counter: controller
// states, action codes and the command and status bundles.
// ----------------------------------------------------------------------------
package ccc_pkg;

    // input action codes
    localparam logic ActAdd    = 1'b0;
    localparam logic ActFinish = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD,
        S_DRAIN,
        S_FIN_RD,
        S_FIN_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;     // latch the input beat
        logic issue;      // read a and a-coin, step the address
        logic clear_wr;   // write the reset value, step the address
        logic fin_rd;     // read the entry at the target
        logic out_load;   // load the result register
        logic addr_zero;  // restart the address at zero
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic last;       // address sits on the top amount
        logic coin_ok;    // incoming coin is inside 1..top amount
        logic out_free;   // result register can take a value
    } t_status;

endpackage

>>> src/coin_change_combination_counter.sv
// ----------------------------------------------------------------------------
// coin_change_combination_counter
// Counts the coin combinations that sum to a target amount.
// ----------------------------------------------------------------------------
// The ways table (MAX_AMOUNT+1 entries of COUNT_WIDTH bits) lives in one RAM
// with a single write port, so all work runs at one table entry per cycle.
// After reset a clearing sweep writes all MAX_AMOUNT+1 entries before the
// first beat is taken. An add beat with coin value c inside 1..MAX_AMOUNT is
// accepted, walks the amounts c..MAX_AMOUNT with one read/add/write each,
// then drains; a coin of 0 or above MAX_AMOUNT leaves the table as it is. A
// finish beat is accepted, reads the entry at the target, loads the result
// register once it is free, then runs a clearing sweep that restores the
// table. A result waiting at the output does not hold up add beats.
// ----------------------------------------------------------------------------
module coin_change_combination_counter #(
    parameter int MAX_AMOUNT  = 4095,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [15:0] i_coin_value,
    input  logic [15:0] i_target_amount,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_way_count,
    output logic        o_saturated,
    output logic        o_amount_out_of_range
);

    ccc_pkg::t_cmd    cmd;
    ccc_pkg::t_status status;

    ccc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    ccc_datapath #(
        .MAX_AMOUNT  (MAX_AMOUNT),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .o_status              (status),
        .i_coin_value          (i_coin_value),
        .i_target_amount       (i_target_amount),
        .i_stall               (i_stall),
        .o_valid               (o_valid),
        .o_way_count           (o_way_count),
        .o_saturated           (o_saturated),
        .o_amount_out_of_range (o_amount_out_of_range)
    );

endmodule

>>> src/ccc_ram.sv
// ----------------------------------------------------------------------------
// ccc_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module ccc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

>>> src/ccc_datapath.sv
// ----------------------------------------------------------------------------
// ccc_datapath
// Ways table, address counter, saturating update stage and result register.
// ----------------------------------------------------------------------------
module ccc_datapath #(
    parameter int MAX_AMOUNT  = 4095,
    parameter int COUNT_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ccc_pkg::t_cmd     i_cmd,
    output ccc_pkg::t_status  o_status,
    input  logic [15:0]       i_coin_value,
    input  logic [15:0]       i_target_amount,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [31:0]       o_way_count,
    output logic              o_saturated,
    output logic              o_amount_out_of_range
);

    localparam int Depth = MAX_AMOUNT + 1;
    localparam int AW    = $clog2(Depth);
    localparam logic [16:0] MaxAmt = 17'(MAX_AMOUNT);

    logic [AW-1:0]          r_addr;
    logic [AW-1:0]          r_coin;
    logic                   r_coin_one;
    logic [AW-1:0]          r_target;
    logic                   r_oor;
    logic                   r_s1_valid;
    logic [AW-1:0]          r_s1_addr;
    logic                   r_s1_first;
    logic [COUNT_WIDTH-1:0] r_last_sum;
    logic                   r_out_valid;
    logic [31:0]            r_way_count;
    logic                   r_saturated;
    logic                   r_oor_out;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [COUNT_WIDTH-1:0] ram_wdata;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr_a;
    logic [AW-1:0]          ram_raddr_b;
    logic [COUNT_WIDTH-1:0] rd_a;
    logic [COUNT_WIDTH-1:0] rd_b;
    logic [COUNT_WIDTH-1:0] low_op;
    logic [COUNT_WIDTH:0]   sum;
    logic [COUNT_WIDTH-1:0] sat_sum;
    logic [COUNT_WIDTH-1:0] init_val;
    logic                   out_free;

    ccc_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (Depth)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_re      (ram_re),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    assign ram_re      = i_cmd.issue | i_cmd.fin_rd;
    assign ram_raddr_a = i_cmd.fin_rd ? r_target : r_addr;
    assign ram_raddr_b = r_addr - r_coin;

    // with a unit coin the entry just below was written on the same edge the
    // read was taken, so take it from the last written value instead
    assign low_op  = (r_coin_one && !r_s1_first) ? r_last_sum : rd_b;
    assign sum     = {1'b0, rd_a} + {1'b0, low_op};
    assign sat_sum = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];

    assign init_val  = (r_addr == '0) ? COUNT_WIDTH'(1) : '0;
    assign ram_we    = r_s1_valid | i_cmd.clear_wr;
    assign ram_waddr = r_s1_valid ? r_s1_addr : r_addr;
    assign ram_wdata = r_s1_valid ? sat_sum : init_val;

    assign out_free = !r_out_valid || !i_stall;

    assign o_status.last     = (r_addr == AW'(MAX_AMOUNT));
    assign o_status.coin_ok  = (i_coin_value != '0) && ({1'b0, i_coin_value} <= MaxAmt);
    assign o_status.out_free = out_free;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            priority if (i_cmd.accept) begin
                r_addr <= i_coin_value[AW-1:0];
            end else if (i_cmd.addr_zero) begin
                r_addr <= '0;
            end else if (i_cmd.issue || i_cmd.clear_wr) begin
                r_addr <= r_addr + AW'(1);
            end
            r_s1_valid <= i_cmd.issue;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_coin     <= i_coin_value[AW-1:0];
            r_coin_one <= (i_coin_value == 16'd1);
            r_target   <= i_target_amount[AW-1:0];
            r_oor      <= ({1'b0, i_target_amount} > MaxAmt);
        end
        r_s1_addr  <= r_addr;
        r_s1_first <= (r_addr == r_coin);
        if (r_s1_valid) begin
            r_last_sum <= sat_sum;
        end
        if (i_cmd.out_load) begin
            r_way_count <= r_oor ? '0 : 32'(rd_a);
            r_saturated <= !r_oor && (rd_a == '1);
            r_oor_out   <= r_oor;
        end
    end

    assign o_valid               = r_out_valid;
    assign o_way_count           = r_way_count;
    assign o_saturated           = r_saturated;
    assign o_amount_out_of_range = r_oor_out;

endmodule

>>> src/ccc_ctrl.sv
// ----------------------------------------------------------------------------
// ccc_ctrl
// Controller: sequences clearing sweeps, coin walks and finish reports.
// ----------------------------------------------------------------------------
module ccc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_action,
    output logic              o_stall,
    input  ccc_pkg::t_status  i_status,
    output ccc_pkg::t_cmd     o_cmd
);

    ccc_pkg::t_state r_state;
    ccc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ccc_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ccc_pkg::S_CLEAR: begin
                if (i_status.last) begin
                    n_state = ccc_pkg::S_IDLE;
                end
            end
            ccc_pkg::S_IDLE: begin
                if (i_valid) begin
                    priority if (i_action == ccc_pkg::ActFinish) begin
                        n_state = ccc_pkg::S_FIN_RD;
                    end else if (i_status.coin_ok) begin
                        n_state = ccc_pkg::S_ADD;
                    end
                end
            end
            ccc_pkg::S_ADD: begin
                if (i_status.last) begin
                    n_state = ccc_pkg::S_DRAIN;
                end
            end
            ccc_pkg::S_DRAIN: begin
                n_state = ccc_pkg::S_IDLE;
            end
            ccc_pkg::S_FIN_RD: begin
                n_state = ccc_pkg::S_FIN_OUT;
            end
            ccc_pkg::S_FIN_OUT: begin
                if (i_status.out_free) begin
                    n_state = ccc_pkg::S_CLEAR;
                end
            end
            default: begin
                n_state = ccc_pkg::S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            ccc_pkg::S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
            end
            ccc_pkg::S_IDLE: begin
                o_stall      = 1'b0;
                o_cmd.accept = i_valid;
            end
            ccc_pkg::S_ADD: begin
                o_cmd.issue = 1'b1;
            end
            ccc_pkg::S_DRAIN: begin
                o_cmd = '0;
            end
            ccc_pkg::S_FIN_RD: begin
                o_cmd.fin_rd = 1'b1;
            end
            ccc_pkg::S_FIN_OUT: begin
                o_cmd.out_load  = i_status.out_free;
                o_cmd.addr_zero = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule
